[src/olwd_pkg.sv]
// Shared types and constants for the ordered value list.
`default_nettype none
package olwd_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DEL  = 2'd1,
    MODE_SHOW = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_APPEND,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    CS_IDLE,
    CS_SHOW
  } ctrl_state_e;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[src/ordered_list_with_delete_by_value.sv]
// Top level: control, result register and the chain of list slots.
`default_nettype none
// Ordered list of up to DEPTH signed 32-bit values held in a chain of slots.
// Add (front in stack mode, back otherwise), delete of the first matching
// value and the unused mode each give one result. A show of n entries gives
// n results, one result per cycle while the output is not stalled: the chain
// rotates one slot per cycle and the front slot is sent out, leaving the list
// in its original order. Requests are held off while a show runs or a result
// waits on a stalled output.
module ordered_list_with_delete_by_value
  import olwd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               mode_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      entry_value_o,
  output logic [1:0]                    status_o,
  output logic                          last_o
);

  ctrl_state_e state_q, state_d;
  logic        front_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_val_q, out_val_d;
  status_e                  out_status_q, out_status_d;
  logic                     out_last_q, out_last_d;

  cell_ctrl_t               cell_ctrl;
  logic signed [DATA_W-1:0] val_w [DEPTH];
  logic [DEPTH-1:0]         vld_w;
  logic [DEPTH:0]           hit_w;

  logic  accept, out_free, full, empty, found, show_last;
  mode_e mode;

  assign mode      = mode_e'(mode_i);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != CS_IDLE) || !out_free;
  assign accept    = in_valid_i && !in_stall_o;
  assign full      = vld_w[DEPTH-1];
  assign empty     = !vld_w[0];
  assign found     = hit_w[DEPTH];
  assign show_last = (CNT_W'(idx_q + 1'b1) == cnt_q);

  // slot chain
  assign hit_w[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_val, next_val;
    logic                     prev_vld, next_vld;
    if (i == 0) begin : g_first
      assign prev_val = value_i;
      assign prev_vld = 1'b1;
    end else begin : g_mid
      assign prev_val = val_w[i-1];
      assign prev_vld = vld_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_val = '0;
      assign next_vld = 1'b0;
    end else begin : g_inner
      assign next_val = val_w[i+1];
      assign next_vld = vld_w[i+1];
    end
    olwd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .prev_val_i (prev_val),
      .prev_vld_i (prev_vld),
      .next_val_i (next_val),
      .next_vld_i (next_vld),
      .head_val_i (val_w[0]),
      .hit_i      (hit_w[i]),
      .hit_o      (hit_w[i+1]),
      .val_o      (val_w[i]),
      .vld_o      (vld_w[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (accept && mode == MODE_SHOW && !empty) state_d = CS_SHOW;
      CS_SHOW: if (out_free && show_last) state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cell_ctrl.op    = OP_HOLD;
    cell_ctrl.value = value_i;
    cnt_d           = cnt_q;
    idx_d           = idx_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_val_d       = out_val_q;
    out_status_d    = out_status_q;
    out_last_d      = out_last_q;
    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          out_val_d    = '0;
          out_status_d = STATUS_OK;
          out_last_d   = 1'b1;
          unique case (mode)
            MODE_ADD: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_status_d = STATUS_FULL;
              end else begin
                cell_ctrl.op = front_q ? OP_PUSH : OP_APPEND;
                cnt_d        = CNT_W'(cnt_q + 1'b1);
              end
            end
            MODE_DEL: begin
              out_valid_d = 1'b1;
              if (found) begin
                cell_ctrl.op = OP_DELETE;
                cnt_d        = CNT_W'(cnt_q - 1'b1);
              end else begin
                out_status_d = STATUS_NOTFOUND;
              end
            end
            MODE_SHOW: begin
              idx_d = '0;
              if (empty) begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_EMPTY;
              end
            end
            MODE_NOP: out_valid_d = 1'b1;
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      CS_SHOW: begin
        if (out_free) begin
          cell_ctrl.op = OP_ROTATE;
          out_valid_d  = 1'b1;
          out_val_d    = val_w[0];
          out_status_d = STATUS_OK;
          out_last_d   = show_last;
          idx_d        = CNT_W'(idx_q + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      front_q     <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) front_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q    <= out_val_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_val_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  // occupied slots form a contiguous run from the front
  a_vld_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_w >> 1) & ~vld_w) == '0)
    else $error("list slots not contiguous");

  // entry counter tracks the slot chain
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_w[DEPTH-1] == (cnt_q == CNT_W'(DEPTH)))
    else $error("entry count disagrees with full slot");

  // a show never runs on an empty list nor past its end
  a_show_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == CS_SHOW |-> (cnt_q != '0) && (idx_q < cnt_q))
    else $error("show index out of range");
`endif

endmodule
`default_nettype wire

[src/olwd_cell.sv]
// One list slot: holds a value and its valid bit, shifts with its neighbors.
`default_nettype none
module olwd_cell
  import olwd_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cell_ctrl_t               ctrl_i,
  input  wire logic signed [DATA_W-1:0] prev_val_i,
  input  wire logic                     prev_vld_i,
  input  wire logic signed [DATA_W-1:0] next_val_i,
  input  wire logic                     next_vld_i,
  input  wire logic signed [DATA_W-1:0] head_val_i,
  input  wire logic                     hit_i,
  output logic                          hit_o,
  output logic signed [DATA_W-1:0]      val_o,
  output logic                          vld_o
);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     vld_q, vld_d;
  logic                     match;

  assign match = vld_q && (val_q == ctrl_i.value);
  assign hit_o = hit_i | match;

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    unique case (ctrl_i.op)
      OP_HOLD: begin
      end
      OP_PUSH: begin
        val_d = prev_val_i;
        vld_d = prev_vld_i;
      end
      OP_APPEND: begin
        // first empty slot takes the value
        if (!vld_q && prev_vld_i) begin
          val_d = ctrl_i.value;
          vld_d = 1'b1;
        end
      end
      OP_DELETE: begin
        // this slot and all after the first match close up
        if (hit_o) begin
          val_d = next_val_i;
          vld_d = next_vld_i;
        end
      end
      OP_ROTATE: begin
        // last occupied slot wraps to the front value
        if (vld_q) begin
          val_d = next_vld_i ? next_val_i : head_val_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;

endmodule
`default_nettype wire

[tb/sv/olwd_checker.sv]
// Checker for the ordered value list: predicts results of each request and compares them.
module olwd_checker
  import olwd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               mode_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] entry_value_i,
  input  logic [1:0]               status_i,
  input  logic                     last_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       results_o,
  output int                       full_drops_o,
  output int                       misses_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] entry_value;
    status_e                  status;
    logic                     last;
  } list_result_t;

  list_result_t             expected_results[$];
  logic signed [DATA_W-1:0] stored_values[$];
  logic                     front_insert;
  int                       fails;
  int                       drops;
  int                       missed;
  int                       checked;

  function automatic list_result_t make_result(logic signed [DATA_W-1:0] v, status_e st,
                                               logic l);
    list_result_t r;
    r.entry_value = v;
    r.status      = st;
    r.last        = l;
    return r;
  endfunction

  task automatic predict_results(input mode_e op, input logic signed [DATA_W-1:0] val);
    int  idx;
    bit  hit;
    int  n;
    case (op)
      MODE_ADD: begin
        if (stored_values.size() >= DEPTH) begin
          expected_results.push_back(make_result('0, STATUS_FULL, 1'b1));
          drops++;
        end else begin
          if (front_insert) stored_values.push_front(val);
          else stored_values.push_back(val);
          expected_results.push_back(make_result('0, STATUS_OK, 1'b1));
        end
      end
      MODE_DEL: begin
        hit = 1'b0;
        idx = 0;
        while (!hit && idx < stored_values.size()) begin
          if (stored_values[idx] == val) begin
            stored_values.delete(idx);
            hit = 1'b1;
          end
          idx++;
        end
        if (hit) begin
          expected_results.push_back(make_result('0, STATUS_OK, 1'b1));
        end else begin
          expected_results.push_back(make_result('0, STATUS_NOTFOUND, 1'b1));
          missed++;
        end
      end
      MODE_SHOW: begin
        n = stored_values.size();
        if (n == 0) begin
          expected_results.push_back(make_result('0, STATUS_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            expected_results.push_back(make_result(stored_values[i], STATUS_OK, i == n - 1));
        end
      end
      default: expected_results.push_back(make_result('0, STATUS_OK, 1'b1));
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      stored_values.delete();
      front_insert = 1'b0;
      fails        = 0;
      drops        = 0;
      missed       = 0;
      checked      = 0;
    end else begin
      if (cfg_we_i) front_insert = cfg_wdata_i;
      // predict first so a same-edge result still pairs with the oldest entry
      if (in_valid_i && !in_stall_i) predict_results(mode_e'(mode_i), value_i);
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: entry_value %0d status %0d last %0d",
                 entry_value_i, status_i, last_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (entry_value_i !== want.entry_value) begin
            $error("entry_value mismatch: expected %0d, actual %0d",
                   want.entry_value, entry_value_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_i);
            fails++;
          end
          if (last_i !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, last_i);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
    results_o    <= checked;
    full_drops_o <= drops;
    misses_o     <= missed;
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the ordered value list: clock, reset, stimulus, stalls and verdict.
module tb;
  import olwd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 90;
  localparam int PHASE_ITEMS = 88;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               mode_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] entry_value_o;
  logic [1:0]               status_o;
  logic                     last_o;

  int fail_count;
  int pending;
  int results_checked;
  int full_drops;
  int misses;

  int mode_sent[4];
  bit idle_on;
  int holds_asked;
  int holds_done;
  int quiet_cycles = 0;

  ordered_list_with_delete_by_value dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .entry_value_o(entry_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  olwd_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .entry_value_i(entry_value_o),
    .status_i     (status_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_checked),
    .full_drops_o (full_drops),
    .misses_o     (misses)
  );

  always #2 clk_i = ~clk_i;

  // pool of repeating values so deletes hit often
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return -1;
      4: return 42;
      5: return -7;
      6: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic mode_e pick_mode(int add_w, int del_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_w) return MODE_ADD;
    if (r < add_w + del_w) return MODE_DEL;
    if (r < 95) return MODE_SHOW;
    return MODE_NOP;
  endfunction

  // returns in the time step of the accepting edge, valid still high
  task automatic send_request(input mode_e m, input logic signed [DATA_W-1:0] v);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mode_sent[m]++;
  endtask

  task automatic sender_gap(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_with_gap(input mode_e m, input logic signed [DATA_W-1:0] v);
    send_request(m, v);
    if (idle_on && $urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 15));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_insert_mode(input bit front);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= front;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int add_w, input int del_w,
                           input bit with_hold, input bit with_pause);
    for (int i = 0; i < items; i++) begin
      if (with_pause && i == items / 3) wait_drained();
      if (with_hold && i == items / 2) begin
        // receiver stalls long while requests keep coming back to back
        holds_asked <= holds_asked + 1;
        for (int k = 0; k < 12; k++) send_request(pick_mode(60, 10), pick_value());
      end
      send_with_gap(pick_mode(add_w, del_w), pick_value());
    end
  endtask

  // receiver side stall pattern
  initial begin
    holds_done = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_asked != holds_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat (idle_on ? $urandom_range(1, 20) : 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_ADD;
    value_i     = '0;
    out_stall_i = 1'b0;
    idle_on     = 1'b1;
    holds_asked = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list cases, extremes, both insert modes, full list
    write_insert_mode(1'b0);
    send_with_gap(MODE_SHOW, 0);
    send_with_gap(MODE_DEL, 5);
    send_with_gap(MODE_NOP, -1);
    send_with_gap(MODE_ADD, 32'sh8000_0000);
    send_with_gap(MODE_ADD, 32'sh7fff_ffff);
    send_with_gap(MODE_ADD, 0);
    send_with_gap(MODE_ADD, -1);
    send_with_gap(MODE_SHOW, 32'sh7fff_ffff);
    send_with_gap(MODE_DEL, 32'sh7fff_ffff);
    send_with_gap(MODE_DEL, 12345);
    write_insert_mode(1'b1);
    send_with_gap(MODE_ADD, 5);
    send_with_gap(MODE_ADD, 5);
    send_with_gap(MODE_DEL, 5);
    send_with_gap(MODE_SHOW, 0);
    for (int i = 0; i < 12; i++) send_with_gap(MODE_ADD, $urandom);
    send_with_gap(MODE_ADD, 77);
    send_with_gap(MODE_SHOW, 0);
    send_with_gap(MODE_DEL, -1);

    write_insert_mode(1'b0);
    run_phase(PHASE_ITEMS, 55, 20, 1'b0, 1'b0);
    write_insert_mode(1'b1);
    run_phase(PHASE_ITEMS, 30, 45, 1'b1, 1'b0);
    write_insert_mode(1'b0);
    run_phase(PHASE_ITEMS, 45, 30, 1'b0, 1'b1);
    idle_on <= 1'b0;
    write_insert_mode(1'b1);
    run_phase(PHASE_ITEMS, 50, 25, 1'b0, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d adds, %0d deletes, %0d shows and %0d no-ops in both insert modes.",
             mode_sent[MODE_ADD], mode_sent[MODE_DEL], mode_sent[MODE_SHOW],
             mode_sent[MODE_NOP]);
    $display("Checked %0d results, %0d adds dropped on a full list, %0d deletes missed.",
             results_checked, full_drops, misses);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
